// File: rtl/core/lpsa_pkg.sv
// Shared constants and types for the lane pair signal arbiter.
`timescale 1ns / 1ps

package lpsa_pkg;

  localparam int NUM_LANES   = 8;
  localparam int NUM_PHASES  = 13;
  localparam int COUNT_WIDTH = 16;
  localparam int ARRIVE_WIDTH = 8;
  localparam int PAIRS_WIDTH = 36;
  localparam int PHASE_WIDTH = 4;
  localparam int LANE_IDX_WIDTH = $clog2(NUM_LANES);
  localparam int GROUP_WIDTH = 2 * LANE_IDX_WIDTH;

  localparam logic [PAIRS_WIDTH-1:0] PAIRS_LOW_RESET  = 36'd28067601680;
  localparam logic [PAIRS_WIDTH-1:0] PAIRS_HIGH_RESET = 36'd55474360236;

  localparam logic [PHASE_WIDTH-1:0] PHASE_ALL_RED = '0;

  typedef enum logic {
    REG_PAIRS_LOW  = 1'b0,
    REG_PAIRS_HIGH = 1'b1
  } cfg_reg_t;

  typedef logic [COUNT_WIDTH-1:0]    count_t;
  typedef logic [ARRIVE_WIDTH-1:0]   arrive_t;
  typedef logic [LANE_IDX_WIDTH-1:0] lane_idx_t;
  typedef logic [PHASE_WIDTH-1:0]    phase_t;

endpackage

// File: rtl/core/lane_pair_signal_arbiter_unit.sv
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle while out_stall is low; counters and the current phase
// update as an item moves from the input register into the result register, in a single pass.
// Reset: synchronous, active high; clears all waiting counters, selects phase 0 (all red),
// empties both registers and restores the lane pair registers to their defaults.
`timescale 1ns / 1ps

module lane_pair_signal_arbiter_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  lpsa_pkg::cfg_reg_t                 cfg_index,
  input  logic [lpsa_pkg::PAIRS_WIDTH-1:0]   cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lpsa_pkg::ARRIVE_WIDTH-1:0]  arrive_lane0,
  input  logic [lpsa_pkg::ARRIVE_WIDTH-1:0]  arrive_lane1,
  input  logic [lpsa_pkg::ARRIVE_WIDTH-1:0]  arrive_lane2,
  input  logic [lpsa_pkg::ARRIVE_WIDTH-1:0]  arrive_lane3,
  input  logic [lpsa_pkg::ARRIVE_WIDTH-1:0]  arrive_lane4,
  input  logic [lpsa_pkg::ARRIVE_WIDTH-1:0]  arrive_lane5,
  input  logic [lpsa_pkg::ARRIVE_WIDTH-1:0]  arrive_lane6,
  input  logic [lpsa_pkg::ARRIVE_WIDTH-1:0]  arrive_lane7,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lpsa_pkg::PHASE_WIDTH-1:0]   green_phase,
  output logic                               all_idle
);

  import lpsa_pkg::*;

  logic [PAIRS_WIDTH-1:0] pairs_low;
  logic [PAIRS_WIDTH-1:0] pairs_high;

  logic    in_reg_valid;
  arrive_t arrive_q [NUM_LANES];
  count_t  lane_waiting [NUM_LANES];
  count_t  lane_waiting_next [NUM_LANES];
  phase_t  current_phase;
  phase_t  phase_next;

  logic advance;
  logic in_accept;

  assign advance   = !out_valid || !out_stall;
  assign in_stall  = in_reg_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pairs_low  <= PAIRS_LOW_RESET;
      pairs_high <= PAIRS_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAIRS_LOW:  pairs_low  <= cfg_data;
        REG_PAIRS_HIGH: pairs_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (advance || !in_reg_valid) begin
      in_reg_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      arrive_q[0] <= arrive_lane0;
      arrive_q[1] <= arrive_lane1;
      arrive_q[2] <= arrive_lane2;
      arrive_q[3] <= arrive_lane3;
      arrive_q[4] <= arrive_lane4;
      arrive_q[5] <= arrive_lane5;
      arrive_q[6] <= arrive_lane6;
      arrive_q[7] <= arrive_lane7;
    end
  end

  // Single pass: saturating add, busy mask, phase pick, service decrement.
  logic [2*PAIRS_WIDTH-1:0] pairs_all;
  count_t                   sat [NUM_LANES];
  logic [COUNT_WIDTH:0]     sum [NUM_LANES];
  logic [NUM_LANES-1:0]     busy;
  lane_idx_t                lane_a [1:NUM_PHASES-1];
  lane_idx_t                lane_b [1:NUM_PHASES-1];
  logic [NUM_PHASES-1:1]    both_wait;
  logic [NUM_PHASES-1:1]    one_wait;
  phase_t                   pick_both;
  phase_t                   pick_one;
  logic                     found_both;
  logic                     found_one;
  logic                     keep_current;
  lane_idx_t                sel_a;
  lane_idx_t                sel_b;
  logic [1:0]               hits [NUM_LANES];

  assign pairs_all = {pairs_high, pairs_low};

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      sum[i]  = {1'b0, lane_waiting[i]} + {{(COUNT_WIDTH + 1 - ARRIVE_WIDTH){1'b0}}, arrive_q[i]};
      sat[i]  = sum[i][COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[i][COUNT_WIDTH-1:0];
      busy[i] = (sat[i] != '0);
    end

    keep_current = 1'b0;
    for (int p = 1; p < NUM_PHASES; p++) begin
      lane_a[p]    = pairs_all[GROUP_WIDTH*(p-1) +: LANE_IDX_WIDTH];
      lane_b[p]    = pairs_all[GROUP_WIDTH*(p-1) + LANE_IDX_WIDTH +: LANE_IDX_WIDTH];
      both_wait[p] = busy[lane_a[p]] && busy[lane_b[p]] && (current_phase != PHASE_WIDTH'(p));
      one_wait[p]  = (busy[lane_a[p]] || busy[lane_b[p]]) && (current_phase != PHASE_WIDTH'(p));
      if (current_phase == PHASE_WIDTH'(p)) begin
        keep_current = busy[lane_a[p]] || busy[lane_b[p]];
      end
    end

    // Walk from the top so the lowest-numbered match wins.
    pick_both  = PHASE_ALL_RED;
    pick_one   = PHASE_ALL_RED;
    found_both = 1'b0;
    found_one  = 1'b0;
    for (int p = NUM_PHASES - 1; p >= 1; p--) begin
      if (both_wait[p]) begin
        pick_both  = PHASE_WIDTH'(p);
        found_both = 1'b1;
      end
      if (one_wait[p]) begin
        pick_one  = PHASE_WIDTH'(p);
        found_one = 1'b1;
      end
    end

    if (found_both) begin
      phase_next = pick_both;
    end else if (found_one) begin
      phase_next = pick_one;
    end else if (keep_current) begin
      phase_next = current_phase;
    end else begin
      phase_next = PHASE_ALL_RED;
    end

    sel_a = '0;
    sel_b = '0;
    for (int p = 1; p < NUM_PHASES; p++) begin
      if (phase_next == PHASE_WIDTH'(p)) begin
        sel_a = lane_a[p];
        sel_b = lane_b[p];
      end
    end

    // A lane named twice in the served phase is taken down by two, stopping at zero.
    for (int i = 0; i < NUM_LANES; i++) begin
      hits[i] = 2'b00;
      if (phase_next != PHASE_ALL_RED) begin
        hits[i] = {1'b0, (sel_a == LANE_IDX_WIDTH'(i))} + {1'b0, (sel_b == LANE_IDX_WIDTH'(i))};
      end
      lane_waiting_next[i] = (sat[i] >= COUNT_WIDTH'(hits[i]))
                             ? sat[i] - COUNT_WIDTH'(hits[i]) : '0;
    end
  end

  // State and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      current_phase <= PHASE_ALL_RED;
      for (int i = 0; i < NUM_LANES; i++) begin
        lane_waiting[i] <= '0;
      end
    end else if (advance) begin
      out_valid <= in_reg_valid;
      if (in_reg_valid) begin
        current_phase <= phase_next;
        for (int i = 0; i < NUM_LANES; i++) begin
          lane_waiting[i] <= lane_waiting_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_reg_valid) begin
      green_phase <= phase_next;
      all_idle    <= (phase_next == PHASE_ALL_RED);
    end
  end

`ifndef SYNTHESIS
  a_idle_matches_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (all_idle == (green_phase == PHASE_ALL_RED)))
    else $error("all_idle disagrees with green_phase");

  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (green_phase < PHASE_WIDTH'(NUM_PHASES)))
    else $error("green_phase out of range");

  a_result_is_current: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (green_phase == current_phase))
    else $error("result phase differs from current phase");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_reg_valid && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  a_state_holds_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(current_phase))
    else $error("current phase moved while the result was held");
`endif

endmodule
